FILE: rtl/oprh_pkg.sv
package oprh_pkg;

    localparam int PATTERN_LEN_DEF = 6;

    localparam int PRICE_W      = 32;
    localparam int COUNT_W      = 32;
    localparam int RATIO_W      = 17;
    localparam int RATIO_FRAC_W = 16;
    localparam int INDEX_W      = 10;
    // Widest counter address, for eight older samples (8! patterns)
    localparam int ADDR_MAX_W   = 16;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_TOTAL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RATIO = 1'b1;

    // Power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               series_start;
    } sample_t;

    typedef struct packed {
        logic [INDEX_W-1:0] pattern_index;
        logic               index_in_range;
        logic               rose;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] total_count;
        logic               qualifies;
    } result_t;

    typedef struct packed {
        logic [ADDR_MAX_W-1:0] addr;
        logic                  in_range;
        logic                  rose;
    } pat_entry_t;

    typedef struct packed {
        logic [COUNT_W-1:0] hit;
        logic [COUNT_W-1:0] total;
    } counts_t;

    function automatic int fact(input int n);
        int r;
        r = 1;
        for (int k = 2; k <= n; k++)
        begin
            r = r * k;
        end
        return r;
    endfunction

endpackage

FILE: rtl/oprh_queue.sv
module oprh_queue
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  oprh_pkg::pat_entry_t                push_data,
    input  logic                                pop,
    output oprh_pkg::pat_entry_t                head,
    output logic                                empty,
    output logic [oprh_pkg::QUEUE_CNT_W-1:0]    count
);

    oprh_pkg::pat_entry_t entry_reg [oprh_pkg::QUEUE_DEPTH];

    logic [oprh_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [oprh_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [oprh_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [oprh_pkg::QUEUE_CNT_W-1:0] count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/oprh_front.sv
module oprh_front
#(
    parameter int PATTERN_LEN = oprh_pkg::PATTERN_LEN_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  oprh_pkg::sample_t                   sample,
    input  logic                                clear_busy,
    input  logic [oprh_pkg::QUEUE_CNT_W-1:0]    q_count,
    output logic                                push,
    output oprh_pkg::pat_entry_t                push_data
);

    localparam int WIN    = PATTERN_LEN + 1;
    localparam int FILL_W = $clog2(WIN + 1);
    localparam int NPAT   = oprh_pkg::fact(PATTERN_LEN);
    localparam int ADDR_W = $clog2(NPAT);
    localparam int RANK_W = $clog2(PATTERN_LEN);
    localparam int DIG_W  = RANK_W + 1;
    localparam int CODE_W = $clog2(PATTERN_LEN * NPAT) + 1;
    localparam int SLOT_W = oprh_pkg::QUEUE_CNT_W + 1;

    logic [oprh_pkg::PRICE_W-1:0] win_reg  [WIN];
    logic [oprh_pkg::PRICE_W-1:0] win_next [WIN];
    logic [FILL_W-1:0]            fill_reg;
    logic [FILL_W-1:0]            fill_next;
    logic [FILL_W-1:0]            fill_base;
    logic                         accept;
    logic [SLOT_W-1:0]            in_flight;

    logic                                       cmp_v_reg;
    logic                                       code_v_reg;
    logic [PATTERN_LEN-1:0][PATTERN_LEN-1:0]    gt_reg;
    logic [PATTERN_LEN-1:0][PATTERN_LEN-1:0]    gt_next;
    logic                                       rose_reg;
    logic                                       rose_next;

    logic [RANK_W-1:0]        rank [PATTERN_LEN];
    logic signed [DIG_W-1:0]  digit;
    logic signed [CODE_W-1:0] code;
    logic                     in_range;

    // Reserve a queue slot for every word still in the compare and code stages
    assign in_flight = {1'b0, q_count} + SLOT_W'(cmp_v_reg) + SLOT_W'(code_v_reg);
    assign sample_ready = !clear_busy && (in_flight < SLOT_W'(oprh_pkg::QUEUE_DEPTH));
    assign accept = sample_valid && sample_ready;

    always_comb
    begin
        fill_base = sample.series_start ? '0 : fill_reg;
        fill_next = fill_reg;
        for (int k = 0; k < WIN; k++)
        begin
            win_next[k] = win_reg[k];
        end
        if (accept)
        begin
            if (fill_base == FILL_W'(WIN))
            begin
                for (int k = 0; k < WIN - 1; k++)
                begin
                    win_next[k] = win_reg[k + 1];
                end
                win_next[WIN-1] = sample.price;
                fill_next = fill_base;
            end
            else
            begin
                for (int k = 0; k < WIN; k++)
                begin
                    if (FILL_W'(k) == fill_base)
                    begin
                        win_next[k] = sample.price;
                    end
                end
                fill_next = fill_base + 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < PATTERN_LEN; i++)
        begin
            for (int j = 0; j < PATTERN_LEN; j++)
            begin
                gt_next[i][j] = (i != j) && (win_reg[i] > win_reg[j]);
            end
        end
        rose_next = win_reg[PATTERN_LEN] > win_reg[PATTERN_LEN-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            cmp_v_reg  <= 1'b0;
            code_v_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            cmp_v_reg  <= accept && (fill_next == FILL_W'(WIN));
            code_v_reg <= cmp_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (cmp_v_reg)
        begin
            gt_reg   <= gt_next;
            rose_reg <= rose_next;
        end
    end

    // Lehmer code; tied ranks may push the sum outside the pattern range
    always_comb
    begin
        for (int i = 0; i < PATTERN_LEN; i++)
        begin
            rank[i] = RANK_W'($countones(gt_reg[i]));
        end
        code  = '0;
        digit = '0;
        for (int i = 0; i < PATTERN_LEN; i++)
        begin
            digit = $signed({1'b0, rank[i]});
            for (int j = 0; j < i; j++)
            begin
                if (rank[i] >= rank[j])
                begin
                    digit = digit - DIG_W'(1);
                end
            end
            code = code + CODE_W'(oprh_pkg::fact(PATTERN_LEN - 1 - i)) * CODE_W'(digit);
        end
        in_range = (code >= 0) && (code < CODE_W'(NPAT));
    end

    assign push               = code_v_reg;
    assign push_data.addr     = in_range ? oprh_pkg::ADDR_MAX_W'(code[ADDR_W-1:0]) : '0;
    assign push_data.in_range = in_range;
    assign push_data.rose     = rose_reg;

endmodule

FILE: rtl/oprh_back.sv
module oprh_back
#(
    parameter int PATTERN_LEN = oprh_pkg::PATTERN_LEN_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [oprh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [oprh_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                q_empty,
    input  oprh_pkg::pat_entry_t                q_head,
    output logic                                pop,
    output logic                                clear_busy,
    output logic                                result_valid,
    input  logic                                result_ready,
    output oprh_pkg::result_t                   result
);

    localparam int NPAT   = oprh_pkg::fact(PATTERN_LEN);
    localparam int ADDR_W = $clog2(NPAT);
    localparam int MUL_W  = oprh_pkg::RATIO_W + oprh_pkg::COUNT_W;

    logic [oprh_pkg::COUNT_W-1:0] min_total_reg;
    logic [oprh_pkg::RATIO_W-1:0] min_ratio_reg;

    logic              clear_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    oprh_pkg::counts_t cnt_mem [NPAT];
    oprh_pkg::counts_t rd_data_reg;

    logic              advance;

    logic              s1_v_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_in_range_reg;
    logic              s1_rose_reg;

    logic              byp_v_reg;
    logic [ADDR_W-1:0] byp_addr_reg;
    oprh_pkg::counts_t byp_data_reg;

    oprh_pkg::counts_t cur;
    oprh_pkg::counts_t upd;
    logic              wr_item;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    oprh_pkg::counts_t wr_data;

    logic                          s2_v_reg;
    logic [oprh_pkg::INDEX_W-1:0]  s2_index_reg;
    logic                          s2_in_range_reg;
    logic                          s2_rose_reg;
    logic [oprh_pkg::COUNT_W-1:0]  s2_hit_reg;
    logic [oprh_pkg::COUNT_W-1:0]  s2_total_reg;

    logic [MUL_W-1:0]   ratio_rhs;
    logic [MUL_W-1:0]   ratio_lhs;
    logic               qualifies;

    logic               result_valid_reg;
    oprh_pkg::result_t  result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_total_reg <= '0;
            min_ratio_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                oprh_pkg::CFG_MIN_TOTAL: min_total_reg <= cfg_data;
                oprh_pkg::CFG_MIN_RATIO: min_ratio_reg <= cfg_data[oprh_pkg::RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero every counter pair once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(NPAT - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    assign clear_busy = clear_reg;

    // The whole back pipeline holds while the result word waits
    assign advance = !result_valid_reg || result_ready;
    assign pop     = advance && !clear_reg && !q_empty;

    // Forward the word written on the edge that issued this read
    always_comb
    begin
        cur = (byp_v_reg && (byp_addr_reg == s1_addr_reg)) ? byp_data_reg : rd_data_reg;
        upd.hit   = (s1_rose_reg && (cur.hit != '1)) ? cur.hit + 1'b1 : cur.hit;
        upd.total = (cur.total != '1) ? cur.total + 1'b1 : cur.total;
        wr_item   = advance && s1_v_reg && s1_in_range_reg;
        wr_en     = clear_reg || wr_item;
        wr_addr   = clear_reg ? clr_addr_reg : s1_addr_reg;
        wr_data   = clear_reg ? '0 : upd;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cnt_mem[wr_addr] <= wr_data;
        end
        if (pop)
        begin
            rd_data_reg <= cnt_mem[q_head.addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg         <= 1'b0;
            s2_v_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            byp_v_reg        <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_v_reg         <= pop;
                s2_v_reg         <= s1_v_reg;
                result_valid_reg <= s2_v_reg;
            end
            if (wr_item)
            begin
                byp_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_addr_reg     <= q_head.addr[ADDR_W-1:0];
            s1_in_range_reg <= q_head.in_range;
            s1_rose_reg     <= q_head.rose;

            s2_index_reg    <= s1_in_range_reg ? oprh_pkg::INDEX_W'(s1_addr_reg) : '0;
            s2_in_range_reg <= s1_in_range_reg;
            s2_rose_reg     <= s1_rose_reg;
            s2_hit_reg      <= s1_in_range_reg ? upd.hit : '0;
            s2_total_reg    <= s1_in_range_reg ? upd.total : '0;

            result_reg.pattern_index  <= s2_index_reg;
            result_reg.index_in_range <= s2_in_range_reg;
            result_reg.rose           <= s2_rose_reg;
            result_reg.hit_count      <= s2_hit_reg;
            result_reg.total_count    <= s2_total_reg;
            result_reg.qualifies      <= qualifies;
        end
        if (wr_item)
        begin
            byp_addr_reg <= s1_addr_reg;
            byp_data_reg <= upd;
        end
    end

    // hits * 2^16 >= min_ratio * total, exact
    assign ratio_rhs = MUL_W'(min_ratio_reg) * MUL_W'(s2_total_reg);
    assign ratio_lhs = MUL_W'({s2_hit_reg, {oprh_pkg::RATIO_FRAC_W{1'b0}}});
    assign qualifies = s2_in_range_reg && (s2_total_reg >= min_total_reg) &&
                       (ratio_lhs >= ratio_rhs);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/ordinal_pattern_rise_histogram_core.sv
// Ordinal-pattern rise histogram. Price words enter on the sample channel; after a series
// start the first PATTERN_LEN words only fill the window, and every later word yields one
// result word carrying the Lehmer index of the older samples' rank pattern, the rise flag
// and the updated saturating hit and total counts for that pattern. The block sustains one
// sample per clock when the result side keeps up: a front section keeps the window and
// computes the index in two register stages, a four-word queue decouples it from the back
// section, which does a read-modify-write of the counter memory (one read and one write
// port, with forwarding between back-to-back words on the same pattern) and then checks the
// ratio threshold with one multiply. After reset the back section zeroes the counter
// memory, one entry per clock, all PATTERN_LEN! entries (720 at the default), and
// sample_ready stays low until that pass ends. Write min_total and min_ratio only while
// no word is in flight.
module ordinal_pattern_rise_histogram_core
#(
    parameter int PATTERN_LEN = oprh_pkg::PATTERN_LEN_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  oprh_pkg::sample_t                   sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output oprh_pkg::result_t                   result,
    input  logic                                cfg_wr_en,
    input  logic [oprh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [oprh_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                             clear_busy;
    logic                             push;
    oprh_pkg::pat_entry_t             push_data;
    logic                             pop;
    oprh_pkg::pat_entry_t             q_head;
    logic                             q_empty;
    logic [oprh_pkg::QUEUE_CNT_W-1:0] q_count;

    oprh_front
    #(
        .PATTERN_LEN (PATTERN_LEN)
    )
    u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .clear_busy   (clear_busy),
        .q_count      (q_count),
        .push         (push),
        .push_data    (push_data)
    );

    oprh_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty),
        .count     (q_count)
    );

    oprh_back
    #(
        .PATTERN_LEN (PATTERN_LEN)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .pop          (pop),
        .clear_busy   (clear_busy),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int PLEN          = oprh_pkg::PATTERN_LEN_DEF;
    localparam int WIN_LEN       = PLEN + 1;
    // 6! rank patterns for the default window
    localparam int PATTERN_COUNT = 720;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    // covers the clearing pass and the long result hold-off many times over
    localparam int WATCHDOG_LIMIT = 5000;

    class histogram_scoreboard;
        bit [oprh_pkg::PRICE_W-1:0] samples[WIN_LEN];
        int                         fill;
        bit [oprh_pkg::COUNT_W-1:0] rise_count[PATTERN_COUNT];
        bit [oprh_pkg::COUNT_W-1:0] seen_count[PATTERN_COUNT];
        bit [oprh_pkg::COUNT_W-1:0] min_total;
        bit [oprh_pkg::RATIO_W-1:0] min_ratio;
        oprh_pkg::result_t          expected_words[$];
        int                         errors;

        function new();
            fill      = 0;
            min_total = '0;
            min_ratio = '0;
            errors    = 0;
            foreach (samples[k])
            begin
                samples[k] = '0;
            end
            foreach (rise_count[k])
            begin
                rise_count[k] = '0;
                seen_count[k] = '0;
            end
        endfunction

        function void write_threshold(logic [oprh_pkg::CFG_INDEX_W-1:0] idx,
                                      logic [oprh_pkg::CFG_DATA_W-1:0] data);
            if (idx == oprh_pkg::CFG_MIN_TOTAL)
                min_total = data;
            else if (idx == oprh_pkg::CFG_MIN_RATIO)
                min_ratio = data[oprh_pkg::RATIO_W-1:0];
        endfunction

        function void note_price(oprh_pkg::sample_t s);
            int                rank[PLEN];
            int                code;
            int                weight;
            int                digit;
            int                k;
            int                j;
            bit                rose;
            oprh_pkg::result_t exp;
            bit [63:0]         lhs;
            bit [63:0]         rhs;

            if (s.series_start)
                fill = 0;
            if (fill >= WIN_LEN)
            begin
                for (k = 0; k < WIN_LEN - 1; k++)
                    samples[k] = samples[k + 1];
                samples[WIN_LEN-1] = s.price;
            end
            else
            begin
                samples[fill] = s.price;
                fill++;
            end
            if (fill < WIN_LEN)
                return;

            for (k = 0; k < PLEN; k++)
            begin
                rank[k] = 0;
                for (j = 0; j < PLEN; j++)
                    if (k != j && samples[k] > samples[j])
                        rank[k]++;
            end
            // Lehmer digits, weights built up from the last position
            code   = 0;
            weight = 1;
            for (k = PLEN - 1; k >= 0; k--)
            begin
                digit = rank[k];
                for (j = 0; j < k; j++)
                    if (rank[k] >= rank[j])
                        digit--;
                code   = code + weight * digit;
                weight = weight * (PLEN - k);
            end

            rose     = samples[PLEN] > samples[PLEN-1];
            exp      = '0;
            exp.rose = rose;
            if (code >= 0 && code < PATTERN_COUNT)
            begin
                if (rose && rise_count[code] != '1)
                    rise_count[code]++;
                if (seen_count[code] != '1)
                    seen_count[code]++;
                exp.pattern_index  = oprh_pkg::INDEX_W'(code);
                exp.index_in_range = 1'b1;
                exp.hit_count      = rise_count[code];
                exp.total_count    = seen_count[code];
                lhs = {16'b0, rise_count[code], 16'b0};
                rhs = 64'(min_ratio) * 64'(seen_count[code]);
                exp.qualifies = (seen_count[code] >= min_total) && (lhs >= rhs);
            end
            expected_words = {expected_words, exp};
        endfunction

        function void check_word(oprh_pkg::result_t act);
            oprh_pkg::result_t exp;

            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: idx=%0d inr=%0b rose=%0b hit=%0d %s%0d q=%0b",
                             act.pattern_index, act.index_in_range, act.rose,
                             act.hit_count, "tot=", act.total_count, act.qualifies);
                return;
            end
            exp = expected_words.pop_front();
            if (exp.pattern_index != act.pattern_index ||
                exp.index_in_range != act.index_in_range ||
                exp.rose != act.rose || exp.hit_count != act.hit_count ||
                exp.total_count != act.total_count || exp.qualifies != act.qualifies)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected idx=%0d inr=%0b rose=%0b hit=%0d tot=%0d q=%0b",
                             exp.pattern_index, exp.index_in_range, exp.rose,
                             exp.hit_count, exp.total_count, exp.qualifies);
                    $display("  actual   idx=%0d inr=%0b rose=%0b hit=%0d tot=%0d q=%0b",
                             act.pattern_index, act.index_in_range, act.rose,
                             act.hit_count, act.total_count, act.qualifies);
                end
            end
        endfunction

        function void check_leftover();
            if (expected_words.size() != 0)
            begin
                errors++;
                $display("%0d result words never arrived", expected_words.size());
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             sample_valid;
    logic                             sample_ready;
    oprh_pkg::sample_t                sample;
    logic                             result_valid;
    logic                             result_ready;
    oprh_pkg::result_t                result;
    logic                             cfg_wr_en;
    logic [oprh_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [oprh_pkg::CFG_DATA_W-1:0]  cfg_data;

    histogram_scoreboard sb;
    int                  send_idle_pct;
    int                  ready_stall_pct;
    bit                  hold_request;
    int                  quiet_cycles;

    ordinal_pattern_rise_histogram_core u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < ready_stall_pct)
                result_ready <= 1'b0;
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_word(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_price(input bit [oprh_pkg::PRICE_W-1:0] price, input bit start);
        oprh_pkg::sample_t s;
        s.price        = price;
        s.series_start = start;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (!sample_ready);
        sb.note_price(s);
    endtask

    task automatic write_threshold(input logic [oprh_pkg::CFG_INDEX_W-1:0] idx,
                                   input logic [oprh_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_threshold(idx, data);
    endtask

    // Drop valid, then wait out every outstanding word and any filling sample in flight
    task automatic drain();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_series(input int n_items);
        int                         sent;
        int                         len;
        int                         mode;
        int                         k;
        bit [oprh_pkg::PRICE_W-1:0] p;
        sent = 0;
        while (sent < n_items)
        begin
            // mostly full series; now and then one too short to fill the window
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(1, PLEN);
            else
                len = $urandom_range(WIN_LEN, 48);
            mode = $urandom_range(0, 4);
            p    = $urandom;
            for (k = 0; k < len && sent < n_items; k++)
            begin
                case (mode)
                    0: p = $urandom_range(0, 3);
                    1: p = $urandom_range(0, 15);
                    2: p = p + $urandom_range(0, 64) - 28;
                    3: p = p - $urandom_range(0, 64) + 28;
                    default: p = $urandom;
                endcase
                send_price(p, (k == 0) || ($urandom_range(0, 39) == 0));
                sent++;
            end
        end
    endtask

    initial
    begin
        int k;
        sb              = new();
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        hold_request    = 1'b0;
        quiet_cycles    = 0;
        rst_n           = 1'b0;
        sample_valid    = 1'b0;
        sample          = '0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_threshold(oprh_pkg::CFG_MIN_TOTAL, 32'd0);
        write_threshold(oprh_pkg::CFG_MIN_RATIO, 32'd0);

        // ascending window, then extremes, an equal pair and a fall
        send_price(32'd0, 1'b1);
        for (k = 1; k <= PLEN; k++)
            send_price(k, 1'b0);
        send_price(32'hFFFF_FFFF, 1'b0);
        send_price(32'hFFFF_FFFF, 1'b0);
        send_price(32'd0, 1'b0);
        // restart on a full window with a descending run: last pattern index
        send_price(32'd60, 1'b1);
        for (k = 1; k <= PLEN; k++)
            send_price(60 - 10 * k, 1'b0);
        // restart while filling, then a fully tied window
        for (k = 0; k < 3; k++)
            send_price(32'd5, k == 0);
        for (k = 0; k < WIN_LEN; k++)
            send_price(32'd5, k == 0);
        drain();

        write_threshold(oprh_pkg::CFG_MIN_TOTAL, 32'd3);
        write_threshold(oprh_pkg::CFG_MIN_RATIO, 32'h1_0000);
        run_series(230);
        drain();

        send_idle_pct = 70;
        write_threshold(oprh_pkg::CFG_MIN_TOTAL, 32'd1);
        write_threshold(oprh_pkg::CFG_MIN_RATIO, 32'h0_8000);
        run_series(230);
        drain();

        send_idle_pct   = 0;
        ready_stall_pct = 70;
        write_threshold(oprh_pkg::CFG_MIN_TOTAL, 32'hFFFF_FFFF);
        write_threshold(oprh_pkg::CFG_MIN_RATIO, 32'd0);
        run_series(230);
        drain();

        send_idle_pct   = 22;
        ready_stall_pct = 22;
        write_threshold(oprh_pkg::CFG_MIN_TOTAL, $urandom_range(0, 4));
        write_threshold(oprh_pkg::CFG_MIN_RATIO, 32'h1_FFFF);
        run_series(230);
        drain();

        send_idle_pct   = 0;
        ready_stall_pct = 0;
        write_threshold(oprh_pkg::CFG_MIN_TOTAL, 32'd0);
        write_threshold(oprh_pkg::CFG_MIN_RATIO, $urandom_range(0, 65536));
        // hold results back long enough to back up the queue and stall samples
        hold_request = 1'b1;
        run_series(60);
        drain();
        run_series(170);
        drain();

        sb.check_leftover();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
